>>> rtl/gpsb_pkg.sv
// Shared types and constants for the Gouraud pixel shader with bounding-box tracking.
// Holds the command, result and queue entry structs, command codes and register indexes.
// No dependencies.
package gpsb_pkg;

  // Command codes on the input side
  localparam logic [1:0] CMD_FRAME_START = 2'd0;
  localparam logic [1:0] CMD_PIXEL       = 2'd1;
  localparam logic [1:0] CMD_FRAME_END   = 2'd2;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_RECT  = 1'b1;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TRACK_ENABLE   = 2'd0;
  localparam logic [1:0] REG_BAND_ACTIVE    = 2'd1;
  localparam logic [1:0] REG_BAND_FIRST_ROW = 2'd2;
  localparam logic [1:0] REG_BAND_END_ROW   = 2'd3;

  localparam logic       TRACK_ENABLE_RESET   = 1'b1;
  localparam logic       BAND_ACTIVE_RESET    = 1'b0;
  localparam logic [7:0] BAND_FIRST_ROW_RESET = 8'd0;
  localparam logic [7:0] BAND_END_ROW_RESET   = 8'd240;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [2:0] corner_first;
    logic [2:0] corner_second;
    logic [2:0] corner_third;
    logic [9:0] weight_first;
    logic [9:0] weight_second;
    logic [9:0] weight_third;
  } command_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] write_address;
    logic [23:0] pixel_color;
    logic [8:0]  rect_x;
    logic [7:0]  rect_y;
    logic [8:0]  rect_w;
    logic [7:0]  rect_h;
  } result_t;

  // One classified item between front and back. For a pixel, col/row give the
  // buffer position (row band-relative when the band is active); for a report, col/row are the
  // box corner and span_w/span_h its size.
  typedef struct packed {
    logic       kind;
    logic [8:0] col;
    logic [7:0] row;
    logic [8:0] span_w;
    logic [7:0] span_h;
    logic [2:0] corner_first;
    logic [2:0] corner_second;
    logic [2:0] corner_third;
    logic [9:0] weight_first;
    logic [9:0] weight_second;
    logic [9:0] weight_third;
  } entry_t;

  typedef struct packed {
    logic       track_enable;
    logic       band_active;
    logic [7:0] band_first_row;
    logic [7:0] band_end_row;
  } cfg_t;

endpackage

>>> rtl/gpsb_front.sv
// Front end: accepts commands, filters band rows, keeps the dirty box.
// Depends on gpsb_pkg; feeds gpsb_queue.
module gpsb_front #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  gpsb_pkg::command_t command,
  input  gpsb_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output gpsb_pkg::entry_t   q_entry
);

  localparam int BXW = ($clog2(SCREEN_WIDTH + 1) > 10) ? $clog2(SCREEN_WIDTH + 1) : 10;
  localparam int BYW = ($clog2(SCREEN_HEIGHT + 1) > 9) ? $clog2(SCREEN_HEIGHT + 1) : 9;

  logic [BXW-1:0] box_left, box_left_next;
  logic [BXW-1:0] box_right_end, box_right_end_next;
  logic [BYW-1:0] box_top, box_top_next;
  logic [BYW-1:0] box_bottom_end, box_bottom_end_next;

  logic           accept;
  logic           in_band;
  logic [BXW-1:0] x_ext, x_end;
  logic [BYW-1:0] y_ext, y_end;
  logic [BXW-1:0] box_w;
  logic [BYW-1:0] box_h;
  logic           box_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign x_ext    = BXW'(command.pixel_x);
  assign x_end    = x_ext + BXW'(1);
  assign y_ext    = BYW'(command.pixel_y);
  assign y_end    = y_ext + BYW'(1);
  assign box_w    = box_right_end - box_left;
  assign box_h    = box_bottom_end - box_top;
  assign box_full = (box_right_end > box_left) && (box_bottom_end > box_top);
  assign in_band  = (command.pixel_y >= cfg.band_first_row) &&
                    (command.pixel_y < cfg.band_end_row);

  always_comb begin
    box_left_next       = box_left;
    box_right_end_next  = box_right_end;
    box_top_next        = box_top;
    box_bottom_end_next = box_bottom_end;
    q_push              = 1'b0;

    q_entry.kind          = gpsb_pkg::KIND_PIXEL;
    q_entry.col           = command.pixel_x;
    q_entry.row           = command.pixel_y;
    q_entry.span_w        = '0;
    q_entry.span_h        = '0;
    q_entry.corner_first  = command.corner_first;
    q_entry.corner_second = command.corner_second;
    q_entry.corner_third  = command.corner_third;
    q_entry.weight_first  = command.weight_first;
    q_entry.weight_second = command.weight_second;
    q_entry.weight_third  = command.weight_third;

    case (command.cmd)
      gpsb_pkg::CMD_FRAME_START: begin
        if (cfg.track_enable) begin
          box_left_next       = BXW'(SCREEN_WIDTH);
          box_right_end_next  = '0;
          box_top_next        = BYW'(SCREEN_HEIGHT);
          box_bottom_end_next = '0;
        end
      end
      gpsb_pkg::CMD_PIXEL: begin
        if (cfg.band_active) begin
          // drop rows the band does not own, address relative to the band
          q_push      = accept && in_band;
          q_entry.row = command.pixel_y - cfg.band_first_row;
        end else begin
          q_push = accept;
          if (cfg.track_enable) begin
            if (x_ext < box_left)       box_left_next       = x_ext;
            if (x_end > box_right_end)  box_right_end_next  = x_end;
            if (y_ext < box_top)        box_top_next        = y_ext;
            if (y_end > box_bottom_end) box_bottom_end_next = y_end;
          end
        end
      end
      gpsb_pkg::CMD_FRAME_END: begin
        q_push         = accept && cfg.track_enable && box_full;
        q_entry.kind   = gpsb_pkg::KIND_RECT;
        q_entry.col    = box_left[8:0];
        q_entry.row    = box_top[7:0];
        q_entry.span_w = box_w[8:0];
        q_entry.span_h = box_h[7:0];
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left       <= BXW'(SCREEN_WIDTH);
      box_right_end  <= '0;
      box_top        <= BYW'(SCREEN_HEIGHT);
      box_bottom_end <= '0;
    end else if (accept) begin
      box_left       <= box_left_next;
      box_right_end  <= box_right_end_next;
      box_top        <= box_top_next;
      box_bottom_end <= box_bottom_end_next;
    end
  end

endmodule

>>> rtl/gpsb_queue.sv
// Short register queue between the front and back halves of the shader.
// Depends on gpsb_pkg for the entry type and depth.
module gpsb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gpsb_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output gpsb_pkg::entry_t  head
);

  gpsb_pkg::entry_t entries [gpsb_pkg::QUEUE_DEPTH];

  logic [gpsb_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [gpsb_pkg::QUEUE_AW:0]   count;
  logic                          do_push, do_pop;

  assign full    = (count == (gpsb_pkg::QUEUE_AW + 1)'(gpsb_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (gpsb_pkg::QUEUE_AW + 1)'(gpsb_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && valid)) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && valid && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

>>> rtl/gpsb_back.sv
// Back end: shades pixels, forms buffer addresses, holds the result register.
// Depends on gpsb_pkg; drains gpsb_queue.
module gpsb_back #(
  parameter int SCREEN_WIDTH     = 320,
  parameter int WEIGHT_ONE_SHIFT = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gpsb_pkg::entry_t  q_head,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output gpsb_pkg::result_t result
);

  // Weighted sum of 0/255 corner channels: 255 * (sum of lit weights), then scale.
  function automatic logic [7:0] mix(input logic [2:0] lit, input logic [9:0] w0,
                                     input logic [9:0] w1, input logic [9:0] w2);
    logic [11:0] s;
    logic [19:0] p;
    logic [19:0] q;
    s = (lit[0] ? 12'(w0) : 12'd0) + (lit[1] ? 12'(w1) : 12'd0) +
        (lit[2] ? 12'(w2) : 12'd0);
    p = {s, 8'd0} - 20'(s);
    q = p >> WEIGHT_ONE_SHIFT;
    return (q > 20'(gpsb_pkg::CHAN_MAX)) ? gpsb_pkg::CHAN_MAX : q[7:0];
  endfunction

  logic              out_valid;
  gpsb_pkg::result_t shaded;
  logic [7:0]        red, green, blue;
  logic [16:0]       row_ext, address;

  // red is lit on even corners, green on bit one, blue on bit two
  assign red   = mix({~q_head.corner_third[0], ~q_head.corner_second[0],
                      ~q_head.corner_first[0]},
                     q_head.weight_first, q_head.weight_second, q_head.weight_third);
  assign green = mix({q_head.corner_third[1], q_head.corner_second[1],
                      q_head.corner_first[1]},
                     q_head.weight_first, q_head.weight_second, q_head.weight_third);
  assign blue  = mix({q_head.corner_third[2], q_head.corner_second[2],
                      q_head.corner_first[2]},
                     q_head.weight_first, q_head.weight_second, q_head.weight_third);

  assign row_ext = 17'(q_head.row);
  assign address = row_ext * 17'(SCREEN_WIDTH) + 17'(q_head.col);

  always_comb begin
    shaded.kind = q_head.kind;
    if (q_head.kind == gpsb_pkg::KIND_RECT) begin
      shaded.write_address = '0;
      shaded.pixel_color   = '0;
      shaded.rect_x        = q_head.col;
      shaded.rect_y        = q_head.row;
      shaded.rect_w        = q_head.span_w;
      shaded.rect_h        = q_head.span_h;
    end else begin
      shaded.write_address = address;
      shaded.pixel_color   = {red, green, blue};
      shaded.rect_x        = '0;
      shaded.rect_y        = '0;
      shaded.rect_w        = '0;
      shaded.rect_h        = '0;
    end
  end

  assign q_pop = q_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= shaded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_pixel_no_rect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.kind == gpsb_pkg::KIND_PIXEL) |->
      (result.rect_w == '0 && result.rect_h == '0))
    else $error("pixel write carries rectangle fields");

  a_rect_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.kind == gpsb_pkg::KIND_RECT) |->
      (result.write_address == '0 && result.pixel_color == '0))
    else $error("rectangle report carries pixel fields");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !out_valid) |=> out_valid)
    else $error("waiting entry not moved to result register");

endmodule

>>> rtl/gouraud_pixel_shader_bbox_core.sv
// Gouraud pixel shader with band filtering and dirty bounding-box tracking.
// An accepted command passes through the queue, then the result register, to the ports;
// one item per cycle sustained while pop keeps the result register free.
// Throughput is set by the combinational shade/address stage in the back end.
// A 4-entry queue decouples the front from the back; full rises only when it fills.
// Reset (rst, synchronous): queue and result register empty, box empty, registers at defaults.
// Depends on gpsb_pkg, gpsb_front, gpsb_queue, gpsb_back.
module gouraud_pixel_shader_bbox_core #(
  parameter int SCREEN_WIDTH     = 320,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int WEIGHT_ONE_SHIFT = 9
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               push,
  output logic               full,
  input  gpsb_pkg::command_t  command,
  // result side
  output logic               empty,
  input  logic               pop,
  output gpsb_pkg::result_t   result,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gpsb_pkg::cfg_t   cfg;
  logic             cfg_write;
  logic [1:0]       reg_index;

  logic             q_push, q_full, q_pop, q_valid;
  gpsb_pkg::entry_t q_entry, q_head;

  // Configuration registers: word-aligned, write on the access phase.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_enable   <= gpsb_pkg::TRACK_ENABLE_RESET;
      cfg.band_active    <= gpsb_pkg::BAND_ACTIVE_RESET;
      cfg.band_first_row <= gpsb_pkg::BAND_FIRST_ROW_RESET;
      cfg.band_end_row   <= gpsb_pkg::BAND_END_ROW_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        gpsb_pkg::REG_TRACK_ENABLE:   cfg.track_enable   <= pwdata[0];
        gpsb_pkg::REG_BAND_ACTIVE:    cfg.band_active    <= pwdata[0];
        gpsb_pkg::REG_BAND_FIRST_ROW: cfg.band_first_row <= pwdata[7:0];
        gpsb_pkg::REG_BAND_END_ROW:   cfg.band_end_row   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (reg_index)
      gpsb_pkg::REG_TRACK_ENABLE:   prdata = 32'(cfg.track_enable);
      gpsb_pkg::REG_BAND_ACTIVE:    prdata = 32'(cfg.band_active);
      gpsb_pkg::REG_BAND_FIRST_ROW: prdata = 32'(cfg.band_first_row);
      gpsb_pkg::REG_BAND_END_ROW:   prdata = 32'(cfg.band_end_row);
      default:                      prdata = '0;
    endcase
  end

  // Front: accept, classify, drop filtered rows, update the dirty box.
  gpsb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .command (command),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Hold classified items so either side can stall alone.
  gpsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Back: shade, address, and present the result item.
  gpsb_back #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .WEIGHT_ONE_SHIFT (WEIGHT_ONE_SHIFT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
